// ===== hdl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg
// Shared widths and codes of the roulette wheel selector.
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int PREFIX_W = 48;
    localparam int RAND_W   = 31;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_TABLE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

// ===== hdl/roulette_wheel_selector.sv =====
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportional selection over integer weights held in two memories.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | operation, fitness_value, last_member,
//           |                      | random_value
//   output  | out_valid / out_ready| selected_index, status
//
// A load marked last with a nonempty table adds a build: a minimum pass
// and a prefix pass, one fitness read per cycle.
// A select runs a bit-serial modulo (skipped for totals of 2^31 and over),
// then a binary search over the prefix memory that alternates a read state
// and a compare state and closes when its bounds meet, then the result state.
// Reset clears only control state; the memories need no clearing pass.
// An earlier output not yet taken holds the block in its result state.
// ----------------------------------------------------------------------------
module roulette_wheel_selector
    import rws_pkg::*;
#(
    parameter int MAX_MEMBERS  = 256,
    parameter int FITNESS_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic signed [31:0]  fitness_value,
    input  logic                last_member,
    input  logic [RAND_W-1:0]   random_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [INDEX_W-1:0]  selected_index,
    output logic [STATUS_W-1:0] status
);

    localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam int BW = $clog2(RAND_W);
    localparam int FB = FITNESS_BITS;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MIN    = 7'b0000010,
        ST_PREF   = 7'b0000100,
        ST_MOD    = 7'b0001000,
        ST_SRD    = 7'b0010000,
        ST_SCMP   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic signed [FB-1:0]   min_reg, min_next;
    logic [PREFIX_W-1:0]    total_reg, total_next;
    logic                   ready_reg, ready_next;
    logic                   ovf_reg, ovf_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic                   rdv_reg, rdv_next;
    logic [AW-1:0]          rdi_reg, rdi_next;
    logic [PREFIX_W-1:0]    acc_reg, acc_next;
    logic [RAND_W-1:0]      rand_reg, rand_next;
    logic [RAND_W-1:0]      rem_reg, rem_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic [AW-1:0]          lo_reg, lo_next;
    logic [AW-1:0]          hi_reg, hi_next;
    logic [AW-1:0]          mid_reg, mid_next;
    logic                   err_reg, err_next;
    logic                   ov_reg, ov_next;
    logic [INDEX_W-1:0]     idx_reg, idx_next;
    logic [STATUS_W-1:0]    st_reg, st_next;

    logic signed [FB-1:0]   fit_mem [MAX_MEMBERS];
    logic [PREFIX_W-1:0]    pref_mem [MAX_MEMBERS];
    logic signed [FB-1:0]   fit_rdata_reg;
    logic [PREFIX_W-1:0]    pref_rdata_reg;
    logic                   fit_we;
    logic [AW-1:0]          fit_waddr;
    logic [AW-1:0]          fit_raddr;
    logic                   pref_we;
    logic [PREFIX_W-1:0]    pref_wdata;
    logic [AW-1:0]          pref_raddr;

    logic signed [FB-1:0]   fit_in;
    logic                   accept;
    logic                   out_free;
    logic [CW-1:0]          eff_count;
    logic [AW-1:0]          last_idx;
    logic [FB-1:0]          diff;
    logic [PREFIX_W-1:0]    weight;
    logic [PREFIX_W-1:0]    acc_base;
    logic [PREFIX_W:0]      acc_sum;
    logic [PREFIX_W-1:0]    acc_new;
    logic [RAND_W:0]        shifted;
    logic [RAND_W:0]        divisor;
    logic [RAND_W-1:0]      rem_step;
    logic [AW:0]            mid_sum;

    generate
        if (FITNESS_BITS <= 32) begin : g_cut
            assign fit_in = fitness_value[FB-1:0];
        end else begin : g_ext
            assign fit_in = {{(FB - 32){fitness_value[31]}}, fitness_value};
        end
    endgenerate

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !ov_reg || out_ready;
    assign eff_count = ready_reg ? '0 : count_reg;
    assign last_idx  = AW'(count_reg - CW'(1));

    assign diff     = FB'(fit_rdata_reg - min_reg);
    assign weight   = (fit_rdata_reg == min_reg) ? PREFIX_W'(1) : PREFIX_W'(diff);
    assign acc_base = (rdi_reg == '0) ? '0 : acc_reg;
    assign acc_sum  = {1'b0, acc_base} + {1'b0, weight};
    assign acc_new  = acc_sum[PREFIX_W] ? {PREFIX_W{1'b1}} : acc_sum[PREFIX_W-1:0];

    assign shifted  = {rem_reg, rand_reg[RAND_W-1]};
    assign divisor  = total_reg[RAND_W:0];
    assign rem_step = (shifted >= divisor) ? RAND_W'(shifted - divisor)
                                           : shifted[RAND_W-1:0];
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};

    assign fit_raddr  = AW'(scan_reg);
    assign pref_wdata = acc_new;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        min_next   = min_reg;
        total_next = total_reg;
        ready_next = ready_reg;
        ovf_next   = ovf_reg;
        scan_next  = scan_reg;
        rdv_next   = 1'b0;
        rdi_next   = rdi_reg;
        acc_next   = acc_reg;
        rand_next  = rand_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        err_next   = err_reg;
        ov_next    = ov_reg;
        idx_next   = idx_reg;
        st_next    = st_reg;
        fit_we     = 1'b0;
        fit_waddr  = AW'(eff_count);
        pref_we    = 1'b0;
        pref_raddr = mid_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_LOAD)
                    begin
                        ready_next = 1'b0;
                        count_next = eff_count;
                        if (eff_count < CW'(MAX_MEMBERS))
                        begin
                            fit_we     = 1'b1;
                            count_next = eff_count + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (last_member && (count_next != '0))
                        begin
                            scan_next  = '0;
                            state_next = ST_MIN;
                        end
                    end
                    else
                    begin
                        err_next  = !ready_reg || (total_reg == '0);
                        rand_next = random_value;
                        rem_next  = '0;
                        bit_next  = '0;
                        lo_next   = '0;
                        hi_next   = last_idx;
                        state_next = err_next ? ST_RESULT : ST_MOD;
                    end
                end
            end
            ST_MIN, ST_PREF:
            begin
                if (scan_reg < count_reg)
                begin
                    rdv_next  = 1'b1;
                    rdi_next  = AW'(scan_reg);
                    scan_next = scan_reg + CW'(1);
                end
                if (rdv_reg)
                begin
                    if (state_reg == ST_MIN)
                    begin
                        if ((rdi_reg == '0) || (fit_rdata_reg < min_reg))
                        begin
                            min_next = fit_rdata_reg;
                        end
                        if (rdi_reg == last_idx)
                        begin
                            scan_next  = '0;
                            rdv_next   = 1'b0;
                            state_next = ST_PREF;
                        end
                    end
                    else
                    begin
                        pref_we  = 1'b1;
                        acc_next = acc_new;
                        if (rdi_reg == last_idx)
                        begin
                            total_next = acc_new;
                            ready_next = 1'b1;
                            rdv_next   = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_MOD:
            begin
                if (total_reg[PREFIX_W-1:RAND_W] != '0)
                begin
                    rem_next   = rand_reg;
                    state_next = ST_SRD;
                end
                else
                begin
                    rem_next  = rem_step;
                    rand_next = rand_reg << 1;
                    bit_next  = bit_reg + BW'(1);
                    if (bit_reg == BW'(RAND_W - 1))
                    begin
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SRD:
            begin
                if (lo_reg == hi_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    mid_next   = AW'(mid_sum >> 1);
                    pref_raddr = AW'(mid_sum >> 1);
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP:
            begin
                if (pref_rdata_reg >= PREFIX_W'(rem_reg))
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + AW'(1);
                end
                state_next = ST_SRD;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (err_reg)
                    begin
                        idx_next = '0;
                        st_next  = STATUS_NO_TABLE;
                    end
                    else
                    begin
                        idx_next = INDEX_W'(lo_reg);
                        st_next  = ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            min_reg   <= '0;
            total_reg <= '0;
            ready_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            scan_reg  <= '0;
            rdv_reg   <= 1'b0;
            err_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            total_reg <= total_next;
            ready_reg <= ready_next;
            ovf_reg   <= ovf_next;
            scan_reg  <= scan_next;
            rdv_reg   <= rdv_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdi_reg  <= rdi_next;
        acc_reg  <= acc_next;
        rand_reg <= rand_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        idx_reg  <= idx_next;
        st_reg   <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (fit_we)
        begin
            fit_mem[fit_waddr] <= fit_in;
        end
        fit_rdata_reg <= fit_mem[fit_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pref_we)
        begin
            pref_mem[rdi_reg] <= pref_wdata;
        end
        pref_rdata_reg <= pref_mem[pref_raddr];
    end

    assign out_valid      = ov_reg;
    assign selected_index = idx_reg;
    assign status         = st_reg;

endmodule

// ===== hdl/rws_checker.sv =====
// ----------------------------------------------------------------------------
// rws_checker
// Port-level checks of the roulette wheel selector, bound to the top level.
// ----------------------------------------------------------------------------
module rws_checker
    import rws_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                operation,
    input logic                out_valid,
    input logic                out_ready,
    input logic [INDEX_W-1:0]  selected_index,
    input logic [STATUS_W-1:0] status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(selected_index) && $stable(status))
        else $error("Output item changed or dropped while stalled.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) || (status == STATUS_NO_TABLE)
                      || (status == STATUS_OVERFLOW))
        else $error("Output status carries an unknown code.");

    a_no_table_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_NO_TABLE) |-> selected_index == '0)
        else $error("A select without a table returned a nonzero index.");

    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == OP_SELECT) |=> !in_ready)
        else $error("A new item was taken while a select was in progress.");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == OP_LOAD) && !out_valid |=> !out_valid)
        else $error("A load produced an output item.");

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .selected_index (selected_index),
    .status         (status)
);
